FILE: rtl/rfrr_pkg.sv
`timescale 1ns / 1ps

package rfrr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned IDX_W    = 9;
    localparam int unsigned CFG_IDX_W = 8;

    // Register reset values
    localparam logic [BYTE_W-1:0] HEADER_RESET   = 8'hA0;
    localparam logic [BYTE_W-1:0] EPC_CODE_RESET = 8'h10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPC_LENGTH_CODE = 8'd1;

    // Byte positions inside a frame
    localparam logic [IDX_W-1:0] POS_HEADER       = 9'd0;
    localparam logic [IDX_W-1:0] POS_LENGTH       = 9'd1;
    localparam logic [IDX_W-1:0] POS_LEN_CODE     = 9'd6;
    localparam logic [IDX_W-1:0] POS_PC_FIRST     = 9'd7;
    localparam logic [IDX_W-1:0] POS_PC_LAST      = 9'd8;
    localparam logic [IDX_W-1:0] POS_EPC_HI_FIRST = 9'd9;
    localparam logic [IDX_W-1:0] POS_EPC_HI_LAST  = 9'd12;
    localparam logic [IDX_W-1:0] POS_EPC_LO_FIRST = 9'd13;
    localparam logic [IDX_W-1:0] POS_EPC_LO_LAST  = 9'd20;
    localparam logic [IDX_W-1:0] POS_CRC_FIRST    = 9'd21;
    localparam logic [IDX_W-1:0] POS_CRC_LAST     = 9'd22;
    localparam logic [IDX_W-1:0] POS_RSSI         = 9'd23;

    typedef enum logic [1:0] {
        STATUS_BUSY  = 2'd0,
        STATUS_GOOD  = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_value;
        logic [BYTE_W-1:0] epc_length_code;
    } rfrr_cfg_t;

    // Per-frame context: parse position, checksum and tag captures
    typedef struct packed {
        logic [IDX_W-1:0]  byte_index;
        logic [IDX_W-1:0]  end_index;
        logic [BYTE_W-1:0] running_sum;
        logic [BYTE_W-1:0] length_code_seen;
        logic [15:0]       pc;
        logic [31:0]       epc_hi;
        logic [63:0]       epc_lo;
        logic [15:0]       crc;
        logic [BYTE_W-1:0] rssi;
    } frame_ctx_t;

    typedef struct packed {
        status_t           status;
        logic              tag_valid;
        logic [15:0]       tag_pc;
        logic [31:0]       epc_upper;
        logic [63:0]       epc_lower;
        logic [15:0]       tag_crc;
        logic [BYTE_W-1:0] tag_rssi;
        logic [BYTE_W-1:0] frame_length;
    } frame_result_t;

endpackage

FILE: rtl/rfrr_step.sv
`timescale 1ns / 1ps

module rfrr_step (
    input  rfrr_pkg::frame_ctx_t    ctx,
    input  rfrr_pkg::rfrr_cfg_t     cfg,
    input  logic [7:0]              rx_byte,
    output rfrr_pkg::frame_ctx_t    ctx_next,
    output rfrr_pkg::frame_result_t result
);
    import rfrr_pkg::*;

    // Shift one frame byte into the capture that owns its position
    function automatic frame_ctx_t capture_byte(frame_ctx_t c, logic [IDX_W-1:0] pos,
                                                logic [BYTE_W-1:0] b);
        frame_ctx_t r;
        r = c;
        if (pos == POS_LEN_CODE) begin
            r.length_code_seen = b;
        end else if (pos >= POS_PC_FIRST && pos <= POS_PC_LAST) begin
            r.pc = {c.pc[7:0], b};
        end else if (pos >= POS_EPC_HI_FIRST && pos <= POS_EPC_HI_LAST) begin
            r.epc_hi = {c.epc_hi[23:0], b};
        end else if (pos >= POS_EPC_LO_FIRST && pos <= POS_EPC_LO_LAST) begin
            r.epc_lo = {c.epc_lo[55:0], b};
        end else if (pos >= POS_CRC_FIRST && pos <= POS_CRC_LAST) begin
            r.crc = {c.crc[7:0], b};
        end else if (pos == POS_RSSI) begin
            r.rssi = b;
        end
        return r;
    endfunction

    logic [BYTE_W-1:0] sum_next;
    status_t           status;
    logic              tag;

    assign sum_next = ctx.running_sum + rx_byte;

    // Parse step
    always_comb
    begin
        ctx_next = ctx;
        status   = STATUS_BUSY;
        tag      = 1'b0;
        if (ctx.byte_index == POS_HEADER)
        begin
            ctx_next.end_index = '0;
            if (rx_byte != cfg.header_value)
            begin
                status = STATUS_ERROR;
            end
            else
            begin
                ctx_next.length_code_seen = '0;
                ctx_next.pc               = '0;
                ctx_next.epc_hi           = '0;
                ctx_next.epc_lo           = '0;
                ctx_next.crc              = '0;
                ctx_next.rssi             = '0;
                ctx_next.running_sum      = rx_byte;
                ctx_next.byte_index       = POS_LENGTH;
            end
        end
        else if (ctx.byte_index == POS_LENGTH)
        begin
            ctx_next.end_index   = {1'b0, rx_byte} + 9'd1;
            ctx_next.running_sum = sum_next;
            ctx_next.byte_index  = ctx.byte_index + 9'd1;
        end
        else if (ctx.byte_index < ctx.end_index)
        begin
            ctx_next             = capture_byte(ctx, ctx.byte_index, rx_byte);
            ctx_next.running_sum = sum_next;
            ctx_next.byte_index  = ctx.byte_index + 9'd1;
        end
        else if (ctx.byte_index == ctx.end_index)
        begin
            ctx_next             = capture_byte(ctx, ctx.byte_index, rx_byte);
            ctx_next.running_sum = sum_next;
            ctx_next.byte_index  = POS_HEADER;
            if (sum_next != '0)
            begin
                status = STATUS_ERROR;
            end
            else
            begin
                status = STATUS_GOOD;
                tag    = (ctx.end_index >= POS_RSSI) &&
                         (ctx_next.length_code_seen == cfg.epc_length_code);
            end
        end
        else
        begin
            // Length byte zero: end position already passed
            status              = STATUS_ERROR;
            ctx_next.byte_index = POS_HEADER;
        end
    end

    // Result item; tag fields read as zero without a tag
    always_comb
    begin
        result.status       = status;
        result.tag_valid    = tag;
        result.tag_pc       = tag ? ctx_next.pc     : '0;
        result.epc_upper    = tag ? ctx_next.epc_hi : '0;
        result.epc_lower    = tag ? ctx_next.epc_lo : '0;
        result.tag_crc      = tag ? ctx_next.crc    : '0;
        result.tag_rssi     = tag ? ctx_next.rssi   : '0;
        result.frame_length = (ctx_next.end_index == '0) ? '0
                            : BYTE_W'(ctx_next.end_index - 9'd1);
    end

endmodule

FILE: rtl/rfrr_frame_receiver.sv
`timescale 1ns / 1ps

// Length-prefixed frame receiver: one received byte per transaction in, one
// result transaction out for every byte, in the cycle after it is taken. The
// frame context (position, 8-bit running sum, tag captures) is read, updated
// and written back for every byte taken, so a new byte can be taken in every
// cycle while in_stall is low; in_stall rises only while the output register
// holds a result that out_stall is holding back. Configuration writes are
// always ready and take effect on the next byte.
module rfid_reader_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  frame_status,
    output logic        tag_valid,
    output logic [15:0] tag_pc,
    output logic [31:0] epc_upper,
    output logic [63:0] epc_lower,
    output logic [15:0] tag_crc,
    output logic [7:0]  tag_rssi,
    output logic [7:0]  frame_length,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rfrr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import rfrr_pkg::*;

    rfrr_cfg_t     cfg_reg;
    frame_ctx_t    ctx_reg;
    frame_ctx_t    ctx_next;
    frame_result_t result_next;
    frame_result_t result_reg;
    logic          out_valid_reg;
    logic          in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    rfrr_step u_step (
        .ctx      (ctx_reg),
        .cfg      (cfg_reg),
        .rx_byte  (rx_byte),
        .ctx_next (ctx_next),
        .result   (result_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value    <= HEADER_RESET;
            cfg_reg.epc_length_code <= EPC_CODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_HEADER_VALUE)
                cfg_reg.header_value <= cfg_data;
            else if (cfg_index == REG_EPC_LENGTH_CODE)
                cfg_reg.epc_length_code <= cfg_data;
        end
    end

    // Frame context write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctx_reg <= '0;
        else if (in_accept)
            ctx_reg <= ctx_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = result_reg.status;
    assign tag_valid    = result_reg.tag_valid;
    assign tag_pc       = result_reg.tag_pc;
    assign epc_upper    = result_reg.epc_upper;
    assign epc_lower    = result_reg.epc_lower;
    assign tag_crc      = result_reg.tag_crc;
    assign tag_rssi     = result_reg.tag_rssi;
    assign frame_length = result_reg.frame_length;

    // A tag report only comes with a good frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tag_valid) |-> (frame_status == STATUS_GOOD))
        else $error("tag reported without good frame");

    // A completed or failed frame leaves the parser hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> ((result_reg.status == STATUS_GOOD ||
                        result_reg.status == STATUS_ERROR)
                       -> (ctx_reg.byte_index == POS_HEADER)))
        else $error("parser not back in hunt after frame end");

    // Tag fields stay zero without a tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tag_valid) |->
            (tag_pc == '0 && epc_upper == '0 && epc_lower == '0 &&
             tag_crc == '0 && tag_rssi == '0))
        else $error("tag fields nonzero without tag");

endmodule
